[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/swfp_pkg.sv]
// ---------------------------------------------------------------------------
// swfp_pkg
// Types and constants shared by the weight frame parser modules.
// ---------------------------------------------------------------------------
package swfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h03;
  localparam logic [7:0] HDR_SECOND = 8'hCE;
  localparam logic [3:0] LEN_SHORT  = 4'd7;
  localparam logic [3:0] LEN_LONG   = 4'd10;
  localparam logic [3:0] COUNT_MAX  = 4'd11;

  // Frame position codes of the header and weight bytes.
  localparam logic [3:0] POS_HDR0 = 4'd0;
  localparam logic [3:0] POS_HDR1 = 4'd1;
  localparam logic [3:0] POS_WHI  = 4'd2;
  localparam logic [3:0] POS_WLO  = 4'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FRAME = 2'd1,
    ST_BAD_SUM   = 2'd2
  } swfp_status_t;

  typedef struct packed {
    logic signed [15:0] weight;
    swfp_status_t       status;
    logic               checked;
  } swfp_res_t;

endpackage

[hdl/swfp_frame_acc.sv]
// ---------------------------------------------------------------------------
// swfp_frame_acc
// Per-frame state (count, XOR, header flag, weight bytes) and the verdict
// formed when the last byte of a frame is consumed.
// ---------------------------------------------------------------------------
module swfp_frame_acc
  import swfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       consume_i,
  output swfp_res_t  res_o
);

  logic [3:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic       header_good_r, header_good_nxt;
  logic [7:0] weight_high_r, weight_high_nxt;
  logic [7:0] weight_low_r, weight_low_nxt;

  logic       hdr_now;
  logic [3:0] total;

  // Header flag including the byte now being consumed.
  always_comb begin
    hdr_now = header_good_r;
    if ((byte_count_r == POS_HDR0) && (byte_i != HDR_FIRST)) begin
      hdr_now = 1'b0;
    end
    if ((byte_count_r == POS_HDR1) && (byte_i != HDR_SECOND)) begin
      hdr_now = 1'b0;
    end
  end

  assign total = (byte_count_r < COUNT_MAX) ? (byte_count_r + 4'd1) : COUNT_MAX;

  always_comb begin
    res_o.weight  = 16'sd0;
    res_o.status  = ST_BAD_FRAME;
    res_o.checked = 1'b0;
    if (((total == LEN_SHORT) || (total == LEN_LONG)) && hdr_now) begin
      res_o.weight = $signed({weight_high_r, weight_low_r});
      res_o.status = ST_OK;
      if (byte_i != 8'd0) begin
        res_o.checked = 1'b1;
        if (running_xor_r != byte_i) begin
          res_o.status = ST_BAD_SUM;
        end
      end
    end
  end

  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_xor_nxt = running_xor_r;
    header_good_nxt = header_good_r;
    weight_high_nxt = weight_high_r;
    weight_low_nxt  = weight_low_r;
    if (consume_i) begin
      if (last_i) begin
        byte_count_nxt  = 4'd0;
        running_xor_nxt = 8'd0;
        header_good_nxt = 1'b1;
        weight_high_nxt = 8'd0;
        weight_low_nxt  = 8'd0;
      end else begin
        byte_count_nxt  = total;
        running_xor_nxt = running_xor_r ^ byte_i;
        header_good_nxt = hdr_now;
        if (byte_count_r == POS_WHI) begin
          weight_high_nxt = byte_i;
        end
        if (byte_count_r == POS_WLO) begin
          weight_low_nxt = byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= 4'd0;
      running_xor_r <= 8'd0;
      header_good_r <= 1'b1;
      weight_high_r <= 8'd0;
      weight_low_r  <= 8'd0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      running_xor_r <= running_xor_nxt;
      header_good_r <= header_good_nxt;
      weight_high_r <= weight_high_nxt;
      weight_low_r  <= weight_low_nxt;
    end
  end

endmodule

[hdl/swfp_out_reg.sv]
// ---------------------------------------------------------------------------
// swfp_out_reg
// Result register holding one verdict until the receiver takes it.
// ---------------------------------------------------------------------------
module swfp_out_reg
  import swfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_i,
  input  swfp_res_t          res_i,
  output logic               free_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_weight_tenths,
  output logic [1:0]         out_status,
  output logic               out_checksum_checked
);

  logic      out_valid_r, out_valid_nxt;
  swfp_res_t res_r;

  assign free_o = !out_valid_r || !out_stall;

  always_comb begin
    if (load_i) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_weight_tenths    = res_r.weight;
  assign out_status           = res_r.status;
  assign out_checksum_checked = res_r.checked;

endmodule

[hdl/scale_weight_frame_parser.sv]
// ---------------------------------------------------------------------------
// scale_weight_frame_parser
// Parses weight notification frames arriving one byte per request and gives
// one verdict with the signed weight for every frame.
// ---------------------------------------------------------------------------
//
//   Channel  | Direction | Request payload
//   ---------+-----------+------------------------------------------------
//   in_      | input     | data_byte[7:0], last_byte
//   out_     | output    | weight_tenths[15:0] signed, status[1:0], checksum_checked
//
// One byte is taken in every clock cycle while nothing stalls.
// An accepted byte waits in the input register until it is consumed; a last
// byte is consumed only while the output register is free, and its verdict
// is loaded into that register as it is consumed. A last byte is thus held
// in the input register and its verdict in the output register before it shows.
// Reset is synchronous and active low; it clears the frame state and empties
// both registers.
// A stalled output holds its verdict; bytes that are not last still drain
// past it, and only a last byte waits behind a stalled verdict.
// ---------------------------------------------------------------------------
module scale_weight_frame_parser
  import swfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_weight_tenths,
  output logic [1:0]         out_status,
  output logic               out_checksum_checked
);

  // Input register: one byte waiting to be folded into the frame state.
  logic       in_full_r, in_full_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  logic       out_free;
  logic       consume;
  logic       accept;
  swfp_res_t  res;

  // A byte that is not last never produces a verdict, so it may be consumed
  // whatever the output register is doing. A last byte needs room there.
  assign consume  = in_full_r && (!last_r || out_free);
  assign in_stall = in_full_r && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      in_full_nxt = 1'b1;
    end else begin
      in_full_nxt = in_full_r && !consume;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  // Frame state and the verdict logic sit between the two registers.
  swfp_frame_acc u_frame_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_i    (byte_r),
    .last_i    (last_r),
    .consume_i (consume),
    .res_o     (res)
  );

  swfp_out_reg u_out_reg (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load_i               (consume && last_r),
    .res_i                (res),
    .free_o               (out_free),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_weight_tenths    (out_weight_tenths),
    .out_status           (out_status),
    .out_checksum_checked (out_checksum_checked)
  );

endmodule

[hdl/swfp_checker.sv]
// ---------------------------------------------------------------------------
// swfp_checker
// Port-level checks on the weight frame parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swfp_checker
  import swfp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_data_byte,
  input logic               in_last_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_weight_tenths,
  input logic [1:0]         out_status,
  input logic               out_checksum_checked
);

  logic [8:0]  in_payload;
  logic [18:0] out_payload;

  assign in_payload  = {in_data_byte, in_last_byte};
  assign out_payload = {out_weight_tenths, out_status, out_checksum_checked};

  // A stalled byte request stays put.
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_payload))

  // A stalled verdict stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // A rejected frame carries no weight and no checksum flag.
  `ASSERT_SAME(a_bad_frame_clean, clk, rst_n, out_valid && (out_status == ST_BAD_FRAME), (out_weight_tenths == 16'sd0) && !out_checksum_checked)

  // A checksum mismatch can only come from an applied check.
  `ASSERT_SAME(a_sum_checked, clk, rst_n, out_valid && (out_status == ST_BAD_SUM), out_checksum_checked)

  // The input side only stalls while a last byte waits on a stalled verdict.
  `ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind scale_weight_frame_parser swfp_checker u_swfp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_data_byte         (in_data_byte),
  .in_last_byte         (in_last_byte),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_weight_tenths    (out_weight_tenths),
  .out_status           (out_status),
  .out_checksum_checked (out_checksum_checked)
);

[bench/tb_scale_weight_frame_parser.sv]
// ---------------------------------------------------------------------------
// tb_scale_weight_frame_parser
// Self-checking bench for the weight frame parser. Frames are streamed into
// the block one byte per request, while a predictor tracks the frame state
// and queues the verdict that each last byte should produce. Every verdict
// that leaves the block is compared field by field with the oldest queued
// expectation, under random idling on both channels and back-pressure.
// ---------------------------------------------------------------------------
module tb_scale_weight_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import swfp_pkg::*;

  // Longest frame the stimulus builds; anything past ten bytes is over-long.
  localparam int MAX_FRAME = 14;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_weight_tenths;
  logic [1:0]         out_status;
  logic               out_checksum_checked;

  scale_weight_frame_parser u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_weight_tenths    (out_weight_tenths),
    .out_status           (out_status),
    .out_checksum_checked (out_checksum_checked)
  );

  // The clock runs with a 20 ns period, starting low.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // -------------------------------------------------------------------------
  // Frame predictor
  // -------------------------------------------------------------------------
  // The bench keeps its own copy of the per-frame state: how many bytes have
  // been seen (saturating at eleven), the XOR of those bytes, whether the
  // header still looks right, and the two weight bytes.
  logic [3:0] frame_len;
  logic [7:0] frame_xor;
  logic       frame_hdr_ok;
  logic [7:0] frame_weight_hi;
  logic [7:0] frame_weight_lo;

  // Verdicts that the block owes us, oldest first.
  swfp_res_t expected_verdicts[$];

  int bytes_sent      = 0;
  int frames_sent     = 0;
  int verdicts_seen   = 0;
  int error_count     = 0;
  int accepted_frames = 0;
  int bad_frames      = 0;
  int bad_sums        = 0;

  function automatic void clear_frame_state();
    frame_len       = 4'd0;
    frame_xor       = 8'h00;
    frame_hdr_ok    = 1'b1;
    frame_weight_hi = 8'h00;
    frame_weight_lo = 8'h00;
  endfunction

  // Advances the predicted frame state by one accepted byte. A last byte
  // closes the frame: its verdict is queued and the state starts afresh,
  // whatever the verdict turned out to be.
  function automatic void track_frame_byte(input logic [7:0] b, input logic last);
    logic [3:0] total;
    swfp_res_t  verdict;
    if (frame_len == POS_HDR0 && b != HDR_FIRST) frame_hdr_ok = 1'b0;
    if (frame_len == POS_HDR1 && b != HDR_SECOND) frame_hdr_ok = 1'b0;
    if (frame_len == POS_WHI) frame_weight_hi = b;
    if (frame_len == POS_WLO) frame_weight_lo = b;
    if (!last) begin
      frame_xor ^= b;
      if (frame_len < COUNT_MAX) frame_len++;
      return;
    end
    total = (frame_len < COUNT_MAX) ? frame_len + 4'd1 : COUNT_MAX;
    verdict.weight  = '0;
    verdict.status  = ST_OK;
    verdict.checked = 1'b0;
    if ((total != LEN_SHORT && total != LEN_LONG) || !frame_hdr_ok) begin
      // Wrong length or a broken header: the weight is not reported.
      verdict.status = ST_BAD_FRAME;
      bad_frames++;
    end else begin
      verdict.weight = {frame_weight_hi, frame_weight_lo};
      // A zero final byte means the sender did not supply a checksum.
      if (b != 8'h00) begin
        verdict.checked = 1'b1;
        if (frame_xor != b) verdict.status = ST_BAD_SUM;
      end
      if (verdict.status == ST_OK) accepted_frames++;
      else bad_sums++;
    end
    expected_verdicts.push_back(verdict);
    clear_frame_state();
  endfunction

  initial clear_frame_state();

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  // Percentage of cycles in which each side holds back. The sender's figure
  // is used by this process only; the receiver's is updated with a
  // nonblocking assignment so that the receiver sees it cleanly.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Offers one byte and waits for the block to take it. Before the request
  // the sender may sit idle for a random number of cycles; valid is only
  // dropped when such a gap is taken, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    track_frame_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fb [0:MAX_FRAME-1], input int len);
    int k;
    for (k = 0; k < len; k++) send_byte(fb[k], k == len - 1);
    frames_sent++;
  endtask

  // Builds and sends one frame with random content. Well-formed frames are
  // seven or ten bytes long and mostly carry the right header; noise
  // frames take any length up to max_len, including over-long ones. The
  // final byte is the correct XOR, zero, or an arbitrary value.
  task automatic send_random_frame(input bit well_formed, input int max_len);
    logic [7:0] fb [0:MAX_FRAME-1];
    logic [7:0] sum;
    int         len;
    int         k;
    int         pick;
    for (k = 0; k < MAX_FRAME; k++) fb[k] = 8'($urandom_range(255));
    if (well_formed) len = $urandom_range(1) ? int'(LEN_SHORT) : int'(LEN_LONG);
    else len = $urandom_range(1, max_len);
    pick = $urandom_range(99);
    if (pick < (well_formed ? 80 : 45)) begin
      fb[0] = HDR_FIRST;
      fb[1] = HDR_SECOND;
    end else if (pick < (well_formed ? 90 : 60)) begin
      // Only the first header byte is right, so the second one decides.
      fb[0] = HDR_FIRST;
    end
    sum = 8'h00;
    for (k = 0; k < len - 1; k++) sum ^= fb[k];
    pick = $urandom_range(99);
    if (pick < 50) fb[len-1] = sum;
    else if (pick < 70) fb[len-1] = 8'h00;
    send_frame(fb, len);
  endtask

  // -------------------------------------------------------------------------
  // Receiver
  // -------------------------------------------------------------------------
  // The receiver stalls at random, or for a long unbroken stretch when a test
  // asks for one. The request counter is bumped by the test; the receiver
  // notices the change and counts the stretch down in its own counter.
  int hold_request = 0;
  int hold_length  = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = hold_length - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Verdict checker
  // -------------------------------------------------------------------------
  // Every verdict taken from the block must match the oldest expectation in
  // each of its three fields. A verdict with nothing queued is a failure too.
  always @(posedge clk) begin : check_verdicts
    swfp_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected verdict: weight %0d status %0d checked %0d",
                 $time, out_weight_tenths, out_status, out_checksum_checked);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_weight_tenths !== want.weight) begin
          error_count++;
          $display("%0t: weight_tenths expected %0d, actual %0d",
                   $time, want.weight, out_weight_tenths);
        end
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d, actual %0d",
                   $time, want.status, out_status);
        end
        if (out_checksum_checked !== want.checked) begin
          error_count++;
          $display("%0t: checksum_checked expected %0d, actual %0d",
                   $time, want.checked, out_checksum_checked);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Hand-built frames at the edges of the format: the most negative and the
  // most positive weight, a good checksum, a skipped checksum, a frame of a
  // single byte, and a checksum that does not match.
  task automatic test_directed_frames();
    logic [7:0] fb [0:MAX_FRAME-1];
    fb = '{0: HDR_FIRST, 1: HDR_SECOND, 2: 8'h80, 6: 8'h4D, default: 8'h00};
    send_frame(fb, int'(LEN_SHORT));
    fb = '{0: HDR_FIRST, 1: HDR_SECOND, 2: 8'h7F, 3: 8'hFF, 4: 8'h11, 5: 8'h22,
           6: 8'h33, 7: 8'h44, 8: 8'h55, default: 8'h00};
    send_frame(fb, int'(LEN_LONG));
    fb = '{0: 8'hFF, default: 8'h00};
    send_frame(fb, 1);
    fb = '{0: HDR_FIRST, 1: HDR_SECOND, 3: 8'h01, 4: 8'hA5, 5: 8'h5A, 6: 8'hFF,
           default: 8'h00};
    send_frame(fb, int'(LEN_SHORT));
  endtask

  // Mostly well-formed frames with random content, the rest noise of any
  // length up to and past the saturation point of the byte count.
  task automatic test_random_frames(input int byte_budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget)
      send_random_frame($urandom_range(99) < 80, MAX_FRAME);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // very short frames, so verdicts pile up and the block stalls its input.
  task automatic test_backpressure_fill();
    int n;
    hold_length  <= 150;
    hold_request <= hold_request + 1;
    for (n = 0; n < 30; n++) send_random_frame(1'b0, 2);
  endtask

  // The sender stops after a few frames and waits until every verdict is
  // back before it carries on, so the block runs dry between bursts.
  task automatic test_pause_for_drain();
    int burst;
    int n;
    for (burst = 0; burst < 3; burst++) begin
      for (n = 0; n < 4; n++) send_random_frame(1'b1, MAX_FRAME);
      in_valid <= 1'b0;
      do @(posedge clk); while (expected_verdicts.size() != 0);
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sender holds back now and then, receiver stalls most of the time.
    set_idling(37, 80);
    test_directed_frames();
    test_random_frames(380);

    // The other way round: a slow sender and a fairly eager receiver.
    set_idling(80, 37);
    test_random_frames(380);

    // Neither side idles; the pressure tests run here as well.
    set_idling(0, 0);
    test_backpressure_fill();
    test_pause_for_drain();
    test_random_frames(380);

    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    // Give the block time to show any stray verdict it might still hold.
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d frames and checked %0d verdicts:", bytes_sent,
             frames_sent, verdicts_seen);
    $display("%0d accepted, %0d bad length or header, %0d bad checksum.",
             accepted_frames, bad_frames, bad_sums);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d verdicts outstanding.", expected_verdicts.size());
    $display("FAILURE");
    $finish;
  end

endmodule

[scale_weight_frame_parser.f]
+incdir+hdl
hdl/swfp_pkg.sv
hdl/swfp_frame_acc.sv
hdl/swfp_out_reg.sv
hdl/scale_weight_frame_parser.sv
hdl/swfp_checker.sv
bench/tb_scale_weight_frame_parser.sv
